FILE: sv/mtdd_pkg.sv
// Package for the three-digit multiplexed display driver.
// Holds the word types, the scan position codes, constants and the segment table.
// No dependencies.
package mtdd_pkg;

    localparam int unsigned MaxValue      = 999;
    localparam logic [7:0]  HoldTicksRst  = 8'd5;

    typedef struct packed {
        logic               kind;    // 0 number, 1 tick
        logic signed [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0] digit_select;
        logic [6:0] segment_pattern;
        logic       accepted;
    } t_out_word;

    typedef enum logic [1:0] {
        POS_ONES     = 2'd0,
        POS_TENS     = 2'd1,
        POS_HUNDREDS = 2'd2
    } t_scan_pos;

    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [2:0] SEL_ONES     = 3'b001;
    localparam logic [2:0] SEL_TENS     = 3'b010;
    localparam logic [2:0] SEL_HUNDREDS = 3'b100;

    localparam logic [6:0] SEG_ZERO = 7'h3F;

    // Segment A in bit 0 through G in bit 6; decimal point never driven.
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h67;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: sv/multiplexed_three_digit_display_driver.sv
// Top level of the three-digit multiplexed seven-segment display driver.
// Depends on mtdd_pkg and mtdd_bin2dec.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_ready   | t_in_word: kind, value
//   out     | output    | o_out_valid / i_out_ready | t_out_word: select, segments, ok
//   cfg     | input     | i_cfg_valid / o_cfg_ready | 8-bit hold_ticks
//
// One word per clock sustained while the output is not stalled; a taken word
// passes through the input register, then the result register, which drives
// the output port.
// Reset (sync, active low) clears the pipeline, shows 0 on the tens digit, hold 5.
// A stalled output holds the result register; the input register still takes a
// word while the result register waits, so ready drops only when both are full.
// Config is always ready; the user must write it only while the block is idle (not enforced).
module multiplexed_three_digit_display_driver
    import mtdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // pipeline registers
    logic      r_a_valid;
    t_in_word  r_a_word;
    logic      r_b_valid;
    t_out_word r_out_word;

    // display state: the shown value is kept as decimal digits
    logic [7:0] r_hold_ticks;
    logic [3:0] r_hund, r_tens, r_ones;
    t_scan_pos  r_pos;
    logic [7:0] r_hold_count;

    logic [3:0] n_hund, n_tens, n_ones;
    t_scan_pos  n_pos;
    logic [7:0] n_hold_count;
    t_out_word  n_out_word;

    logic       w_adv;
    logic       w_fire;
    logic       w_in_range;
    logic [3:0] w_cv_hund, w_cv_tens, w_cv_ones;
    logic [7:0] w_limit;
    logic [8:0] w_cnt;
    logic [3:0] w_digit;

    assign w_adv       = !r_b_valid || i_out_ready;
    assign w_fire      = r_a_valid && w_adv;
    assign o_in_ready  = !r_a_valid || w_adv;
    assign o_out_valid = r_b_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // negative or above 999 is rejected
    assign w_in_range = !r_a_word.value[15] && (r_a_word.value[14:0] <= 15'(MaxValue));

    mtdd_bin2dec u_bin2dec (
        .i_value    (r_a_word.value[9:0]),
        .o_hundreds (w_cv_hund),
        .o_tens     (w_cv_tens),
        .o_ones     (w_cv_ones)
    );

    // hold of zero behaves as one
    assign w_limit = (r_hold_ticks == 8'd0) ? 8'd1 : r_hold_ticks;
    assign w_cnt   = {1'b0, r_hold_count} + 9'd1;

    // next display state
    always_comb begin
        n_hund       = r_hund;
        n_tens       = r_tens;
        n_ones       = r_ones;
        n_pos        = r_pos;
        n_hold_count = r_hold_count;
        if (r_a_word.kind == KIND_NUMBER) begin
            if (w_in_range) begin
                n_hund       = w_cv_hund;
                n_tens       = w_cv_tens;
                n_ones       = w_cv_ones;
                n_hold_count = 8'd0;
                n_pos        = (w_cv_hund != 4'd0) ? POS_HUNDREDS : POS_TENS;
            end
        end else begin
            if (w_cnt >= {1'b0, w_limit}) begin
                n_hold_count = 8'd0;
                case (r_pos)
                    POS_HUNDREDS: n_pos = POS_TENS;
                    POS_TENS:     n_pos = POS_ONES;
                    // wrap: hundreds only when the value has one
                    POS_ONES:     n_pos = (r_hund != 4'd0) ? POS_HUNDREDS : POS_TENS;
                    default:      n_pos = POS_TENS;
                endcase
            end else begin
                n_hold_count = w_cnt[7:0];
            end
        end
    end

    // result describes the digit lit after the word
    always_comb begin
        case (n_pos)
            POS_HUNDREDS: begin
                n_out_word.digit_select = SEL_HUNDREDS;
                w_digit                 = n_hund;
            end
            POS_ONES: begin
                n_out_word.digit_select = SEL_ONES;
                w_digit                 = n_ones;
            end
            default: begin
                n_out_word.digit_select = SEL_TENS;
                w_digit                 = n_tens;
            end
        endcase
        n_out_word.segment_pattern = seg_of(w_digit);
        n_out_word.accepted        = (r_a_word.kind == KIND_TICK) || w_in_range;
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_hold_ticks <= HoldTicksRst;
            r_hund       <= 4'd0;
            r_tens       <= 4'd0;
            r_ones       <= 4'd0;
            r_pos        <= POS_TENS;
            r_hold_count <= 8'd0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_b_valid <= r_a_valid;
            end
            if (i_cfg_valid) begin
                r_hold_ticks <= i_cfg_data;
            end
            if (w_fire) begin
                r_hund       <= n_hund;
                r_tens       <= n_tens;
                r_ones       <= n_ones;
                r_pos        <= n_pos;
                r_hold_count <= n_hold_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_a_word <= i_in_word;
        end
        if (w_fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

FILE: sv/mtdd_bin2dec.sv
// Binary to decimal digit split for values 0..999.
// Parallel compares against multiples of 100 and 10; depends on mtdd_pkg.
module mtdd_bin2dec
    import mtdd_pkg::*;
(
    input  logic [9:0] i_value,
    output logic [3:0] o_hundreds,
    output logic [3:0] o_tens,
    output logic [3:0] o_ones
);

    logic [9:0] w_rem100;
    logic [6:0] w_rem10;

    always_comb begin
        o_hundreds = 4'd0;
        w_rem100   = i_value;
        for (int k = 1; k <= 9; k++) begin
            if (i_value >= 10'(k * 100)) begin
                o_hundreds = 4'(k);
                w_rem100   = i_value - 10'(k * 100);
            end
        end
    end

    always_comb begin
        o_tens  = 4'd0;
        w_rem10 = w_rem100[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (w_rem100[6:0] >= 7'(k * 10)) begin
                o_tens  = 4'(k);
                w_rem10 = w_rem100[6:0] - 7'(k * 10);
            end
        end
        o_ones = w_rem10[3:0];
    end

endmodule

FILE: sv/mtdd_checker.sv
// Port-level checks for the display driver, bound to the top level.
// Depends on mtdd_pkg.
module mtdd_checker
    import mtdd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result changed while stalled");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_out_word.digit_select)
            && o_out_word.digit_select != 3'b011)
        else $error("digit select not one-hot");

    // hundreds is lit only for a value above 99, so its digit is never zero
    a_hund_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.digit_select == SEL_HUNDREDS
            |-> o_out_word.segment_pattern != SEG_ZERO)
        else $error("hundreds digit lit with zero");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind multiplexed_three_digit_display_driver mtdd_checker u_mtdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

FILE: tb/multiplexed_three_digit_display_driver_tb.sv
// Self-checking testbench for the three-digit multiplexed display driver.
// Needs mtdd_pkg and the driver RTL; a scoreboard class predicts every result word.
module multiplexed_three_digit_display_driver_tb
    import mtdd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WatchdogLimit = 3000;  // cycles without any handshake
    localparam int unsigned LongStall     = 60;    // receiver hold-off, fills the block
    localparam int unsigned PhaseWords    = 160;   // random words per hold setting

    // Predicts the lit digit after every accepted input word and holds the
    // expected result words in arrival order.
    class scan_predictor;
        logic [7:0] hold_ticks;
        logic [9:0] shown_value;
        t_scan_pos  scan_pos;
        logic [7:0] hold_count;
        t_out_word  lit_queue[$];
        int         mismatches;

        function new();
            hold_ticks  = HoldTicksRst;
            shown_value = '0;
            scan_pos    = POS_TENS;
            hold_count  = '0;
            mismatches  = 0;
        endfunction

        function void set_hold(logic [7:0] ticks);
            hold_ticks = ticks;
        endfunction

        function int pending();
            return lit_queue.size();
        endfunction

        // Scan starts on hundreds only when there is a hundreds digit to show.
        function t_scan_pos lead_pos(logic [9:0] v);
            return (v > 10'd99) ? POS_HUNDREDS : POS_TENS;
        endfunction

        function t_out_word lit_digit(logic ok);
            logic [6:0] segs [10];
            t_out_word  w;
            int         sv;
            int         d;
            segs = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67};
            sv = int'(shown_value);
            case (scan_pos)
                POS_HUNDREDS: begin
                    d = (sv / 100) % 10;
                    w.digit_select = SEL_HUNDREDS;
                end
                POS_ONES: begin
                    d = sv % 10;
                    w.digit_select = SEL_ONES;
                end
                default: begin
                    d = (sv % 100) / 10;
                    w.digit_select = SEL_TENS;
                end
            endcase
            w.segment_pattern = segs[d];
            w.accepted        = ok;
            return w;
        endfunction

        function void note_word(t_in_word w);
            logic [15:0] raw;
            logic [8:0]  limit;
            logic [8:0]  next_count;
            logic        ok;
            raw = w.value;
            ok  = 1'b1;
            if (w.kind == KIND_NUMBER) begin
                // negative or above the display range: keep the old value
                if (raw[15] || raw > MaxValue) begin
                    ok = 1'b0;
                end else begin
                    shown_value = raw[9:0];
                    hold_count  = '0;
                    scan_pos    = lead_pos(raw[9:0]);
                end
            end else begin
                // zero hold behaves as one; >= lets a lowered hold take effect at once
                limit      = (hold_ticks == 8'd0) ? 9'd1 : {1'b0, hold_ticks};
                next_count = {1'b0, hold_count} + 9'd1;
                if (next_count >= limit) begin
                    hold_count = '0;
                    case (scan_pos)
                        POS_HUNDREDS: scan_pos = POS_TENS;
                        POS_TENS:     scan_pos = POS_ONES;
                        POS_ONES:     scan_pos = lead_pos(shown_value);
                        default:      scan_pos = POS_TENS;
                    endcase
                end else begin
                    hold_count = next_count[7:0];
                end
            end
            lit_queue.push_back(lit_digit(ok));
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (lit_queue.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                mismatches++;
            end else begin
                want = lit_queue.pop_front();
                if (got.digit_select !== want.digit_select) begin
                    $error("digit_select: expected %h, got %h",
                           want.digit_select, got.digit_select);
                    mismatches++;
                end
                if (got.segment_pattern !== want.segment_pattern) begin
                    $error("segment_pattern: expected %h, got %h",
                           want.segment_pattern, got.segment_pattern);
                    mismatches++;
                end
                if (got.accepted !== want.accepted) begin
                    $error("accepted: expected %b, got %b", want.accepted, got.accepted);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset and DUT hookup. Every input has a known value at time 0.
    // ---------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = '0;

    scan_predictor scoreboard = new();

    // Receiver behavior, set by the main sequence.
    int unsigned rx_gap_pct = 0;    // chance per cycle of starting a stall burst
    bit          stall_req  = 1'b0; // one long hold-off, picked up by the receiver
    int unsigned tx_gap_pct = 0;    // chance per word of a sender gap

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    multiplexed_three_digit_display_driver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // Monitor: every handshake is seen at the rising edge. Inputs only
    // change on the falling edge, so the sampled values are settled.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) scoreboard.set_hold(i_cfg_data);
            if (i_in_valid && o_in_ready)   scoreboard.note_word(i_in_word);
            if (o_out_valid && i_out_ready) scoreboard.check_word(o_out_word);
        end
    end

    // Watchdog: too long without any word moving means the block hung.
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    // At most one assignment to ready per falling edge.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LongStall - 1) @(negedge i_clk);
            end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driving tasks
    // ---------------------------------------------------------------------

    // Offer one word from the falling edge and hold it until taken.
    task automatic send_word(input logic kind, input logic [15:0] value);
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_in_word.kind  <= kind;
        i_in_word.value <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop offering and wait for every expected word to come out, then let
    // the two-stage pipe settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called with the block idle, right after drain().
    task automatic write_hold(input logic [7:0] ticks);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_word(KIND_TICK, 16'($urandom));
    endtask

    // Mostly ticks and in-range numbers, the rest raw noise on both fields.
    task automatic send_random();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)      send_word(KIND_TICK, 16'($urandom));
        else if (pick < 80) send_word(KIND_NUMBER, 16'($urandom_range(0, 99)));
        else if (pick < 92) send_word(KIND_NUMBER, 16'($urandom_range(100, 999)));
        else                send_word(1'($urandom), 16'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [7:0]  phase_hold;
        int unsigned phase_tx [6];
        int unsigned phase_rx [6];
        logic [7:0]  phase_holds [6];
        phase_tx    = '{20, 30, 0, 25, 15, 0};
        phase_rx    = '{20, 0, 30, 25, 15, 0};
        phase_holds = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd0, 8'd3};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default hold of 5: the fifth tick moves tens to ones.
        send_ticks(5);
        send_word(KIND_NUMBER, 16'd0);
        send_word(KIND_NUMBER, 16'd999);
        send_word(KIND_NUMBER, 16'd1000);   // just out of range
        send_word(KIND_NUMBER, 16'hFFFF);   // negative
        send_word(KIND_NUMBER, 16'h8000);   // most negative
        send_word(KIND_NUMBER, 16'h7FFF);   // most positive
        drain();

        // Zero hold acts as one: every tick steps the scan. Two-digit value
        // wraps ones -> tens, three-digit value wraps ones -> hundreds.
        write_hold(8'd0);
        send_word(KIND_NUMBER, 16'd99);
        send_ticks(3);
        send_word(KIND_NUMBER, 16'd100);
        send_ticks(3);
        drain();

        // Hold lowered below the running count: next tick must advance.
        write_hold(8'd10);
        send_word(KIND_NUMBER, 16'd547);
        send_ticks(6);
        drain();
        write_hold(8'd3);
        send_ticks(2);
        drain();

        // Random phases, one hold setting each; the last runs with no idling.
        for (int p = 0; p < 6; p++) begin
            phase_hold = (p == 4) ? 8'($urandom_range(4, 254)) : phase_holds[p];
            write_hold(phase_hold);
            tx_gap_pct = phase_tx[p];
            rx_gap_pct = phase_rx[p];
            for (int unsigned n = 0; n < PhaseWords; n++) begin
                if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
                    sender_gap($urandom_range(1, 7));
                // sender keeps pushing through this, so the block backs up
                if (p == 1 && n == PhaseWords / 2) stall_req = 1'b1;
                send_random();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
